// ===== design/nts_pkg.sv =====
// ----------------------------------------------------------------------------
// nts_pkg - shared types and constants for the N-d tensor element store
// Field widths, register codes and the status records passed between parts.
// ----------------------------------------------------------------------------
package nts_pkg;

  // index fields carried by every request
  localparam int IDX_FIELDS = 4;
  // dimensions the store supports at most
  localparam int MAX_DIMS   = 4;

  localparam int IDX_W      = 10;
  localparam int DIM_W      = 11;
  localparam int NDIM_W     = 3;
  localparam int DIM_SEL_W  = $clog2(IDX_FIELDS);
  localparam int VALUE_W    = 32;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 11;

  // dimension count after saturation never exceeds this
  localparam logic [NDIM_W-1:0] DIM_CAP =
    NDIM_W'((MAX_DIMS < IDX_FIELDS) ? MAX_DIMS : IDX_FIELDS);

  // front-to-back queue
  localparam int QDEPTH = 4;
  localparam int QPTR_W = $clog2(QDEPTH);
  localparam int QCNT_W = $clog2(QDEPTH + 1);

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_NUM_DIMS   = 3'd0,
    CFG_DIM_SIZE_0 = 3'd1,
    CFG_DIM_SIZE_1 = 3'd2,
    CFG_DIM_SIZE_2 = 3'd3,
    CFG_DIM_SIZE_3 = 3'd4
  } cfg_reg_t;

  typedef enum logic {
    REQ_GET = 1'b0,
    REQ_SET = 1'b1
  } req_type_t;

  typedef struct packed {
    logic              empty;
    logic [QCNT_W-1:0] count;
  } q_status_t;

  typedef struct packed {
    logic clearing;
  } back_status_t;

endpackage

// ===== design/nts_queue.sv =====
// ----------------------------------------------------------------------------
// nts_queue - short request queue between front and back
// Small register FIFO; the front only pushes when it holds credit.
// ----------------------------------------------------------------------------
module nts_queue #(
  parameter int WIDTH = 44
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                push,
  input  logic [WIDTH-1:0]    push_data,
  input  logic                pop,
  output logic [WIDTH-1:0]    pop_data,
  output nts_pkg::q_status_t  q_st
);
  import nts_pkg::*;

  logic [WIDTH-1:0]  slots [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QCNT_W-1:0] count;

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + QPTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + QPTR_W'(1);
      end
      case ({push, pop})
        2'b10:   count <= count + QCNT_W'(1);
        2'b01:   count <= count - QCNT_W'(1);
        default: count <= count;
      endcase
    end
  end

  assign pop_data   = slots[rd_ptr];
  assign q_st.empty = (count == '0);
  assign q_st.count = count;

  // front credit must keep the queue from overflowing
  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    push |-> (count < QCNT_W'(QDEPTH)))
    else $error("queue push while full");

  a_no_underflow: assert property (@(posedge clk) disable iff (rst)
    pop |-> (count != '0))
    else $error("queue pop while empty");

endmodule

// ===== design/nts_front.sv =====
// ----------------------------------------------------------------------------
// nts_front - configuration, stride sequencer and address classification
// Holds the shape registers, rebuilds strides, checks indices and forms the
// flat address of each request before queueing it for the back end.
// ----------------------------------------------------------------------------
module nts_front #(
  parameter int STORE_DEPTH = 1024,
  parameter int DATA_WIDTH  = 32
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              req_valid,
  output logic                              req_stall,
  input  logic                              req_type,
  input  logic [nts_pkg::IDX_W-1:0]         index_0,
  input  logic [nts_pkg::IDX_W-1:0]         index_1,
  input  logic [nts_pkg::IDX_W-1:0]         index_2,
  input  logic [nts_pkg::IDX_W-1:0]         index_3,
  input  logic [nts_pkg::VALUE_W-1:0]       write_value,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [nts_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [nts_pkg::CFG_DATA_W-1:0]    cfg_data,
  input  nts_pkg::back_status_t             back_st,
  input  nts_pkg::q_status_t                q_st,
  output logic                              push,
  output logic [$clog2(STORE_DEPTH)+DATA_WIDTH+1:0] push_data
);
  import nts_pkg::*;

  localparam int ADDR_W = $clog2(STORE_DEPTH);
  // strides are clamped at STORE_DEPTH: anything that large already errors
  localparam int SW     = $clog2(STORE_DEPTH + 1);
  localparam int MW     = SW + DIM_W;
  localparam int PW     = SW + IDX_W;
  localparam int FLAT_W = PW + 2;

  logic [NDIM_W-1:0]    num_dims;
  logic [DIM_W-1:0]     dim_size [IDX_FIELDS];
  logic [SW-1:0]        stride   [IDX_FIELDS];
  logic                 busy;
  logic                 init;
  logic [DIM_SEL_W-1:0] k;

  logic [NDIM_W-1:0]    n_use;
  logic [DIM_SEL_W-1:0] last_dim;
  logic [MW-1:0]        mprod;
  logic [SW-1:0]        stride_next;
  logic                 cfg_hit;
  logic                 cfg_known;

  // dimension count: zero means one, large values saturate
  always_comb begin
    if (num_dims == '0) begin
      n_use = NDIM_W'(1);
    end else if (num_dims > DIM_CAP) begin
      n_use = DIM_CAP;
    end else begin
      n_use = num_dims;
    end
  end

  assign last_dim    = DIM_SEL_W'(n_use - NDIM_W'(1));
  assign mprod       = MW'(stride[k]) * MW'(dim_size[k]);
  assign stride_next = (mprod > MW'(STORE_DEPTH)) ? SW'(STORE_DEPTH) : SW'(mprod);

  assign cfg_ready = !busy;
  assign cfg_hit   = cfg_valid && cfg_ready;

  always_comb begin
    case (cfg_index)
      CFG_NUM_DIMS,
      CFG_DIM_SIZE_0,
      CFG_DIM_SIZE_1,
      CFG_DIM_SIZE_2,
      CFG_DIM_SIZE_3: cfg_known = 1'b1;
      default:        cfg_known = 1'b0;
    endcase
  end

  // shape registers and stride rebuild, one multiply per cycle
  always_ff @(posedge clk) begin
    if (rst) begin
      num_dims <= NDIM_W'(1);
      for (int i = 0; i < IDX_FIELDS; i++) begin
        dim_size[i] <= (i == 0) ? DIM_W'(1024) : DIM_W'(1);
        stride[i]   <= (i == 0) ? SW'(1) : SW'(0);
      end
      busy <= 1'b0;
      init <= 1'b0;
      k    <= '0;
    end else if (cfg_hit) begin
      case (cfg_index)
        CFG_NUM_DIMS:   num_dims    <= cfg_data[NDIM_W-1:0];
        CFG_DIM_SIZE_0: dim_size[0] <= cfg_data;
        CFG_DIM_SIZE_1: dim_size[1] <= cfg_data;
        CFG_DIM_SIZE_2: dim_size[2] <= cfg_data;
        CFG_DIM_SIZE_3: dim_size[3] <= cfg_data;
        default:        ;
      endcase
      busy <= cfg_known;
      init <= cfg_known;
    end else if (init) begin
      for (int i = 0; i < IDX_FIELDS; i++) begin
        stride[i] <= (DIM_SEL_W'(i) == last_dim) ? SW'(1) : SW'(0);
      end
      k    <= last_dim;
      init <= 1'b0;
    end else if (busy) begin
      if (k == '0) begin
        busy <= 1'b0;
      end else begin
        stride[k - DIM_SEL_W'(1)] <= stride_next;
        k <= k - DIM_SEL_W'(1);
      end
    end
  end

  // request path
  logic [IDX_W-1:0]      idx [IDX_FIELDS];
  logic [QCNT_W:0]       credit;
  logic                  accept;
  logic                  ierr;
  logic [PW-1:0]         prod [IDX_FIELDS];

  logic                  p1_valid;
  logic                  p1_set;
  logic                  p1_ierr;
  logic [PW-1:0]         p1_prod [IDX_FIELDS];
  logic [DATA_WIDTH-1:0] p1_data;

  logic [FLAT_W-1:0]     flat;
  logic                  err;

  assign idx[0] = index_0;
  assign idx[1] = index_1;
  assign idx[2] = index_2;
  assign idx[3] = index_3;

  assign credit    = (QCNT_W+1)'(q_st.count) + (QCNT_W+1)'(p1_valid);
  assign req_stall = busy || back_st.clearing || (credit >= (QCNT_W+1)'(QDEPTH));
  assign accept    = req_valid && !req_stall;

  // unused dimensions carry zero stride, so their products vanish
  always_comb begin
    ierr = 1'b0;
    for (int i = 0; i < IDX_FIELDS; i++) begin
      prod[i] = PW'(idx[i]) * PW'(stride[i]);
      if ((NDIM_W'(i) < n_use) && ({1'b0, idx[i]} >= dim_size[i])) begin
        ierr = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      p1_valid <= 1'b0;
    end else begin
      p1_valid <= accept;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      p1_set  <= (req_type == REQ_SET);
      p1_ierr <= ierr;
      p1_data <= DATA_WIDTH'(write_value);
      for (int i = 0; i < IDX_FIELDS; i++) begin
        p1_prod[i] <= prod[i];
      end
    end
  end

  always_comb begin
    flat = '0;
    for (int i = 0; i < IDX_FIELDS; i++) begin
      flat = flat + FLAT_W'(p1_prod[i]);
    end
  end

  assign err       = p1_ierr || (flat >= FLAT_W'(STORE_DEPTH));
  assign push      = p1_valid;
  assign push_data = {p1_set, err, flat[ADDR_W-1:0], p1_data};

  // rebuild: setup cycle, one multiply per outer stride, closing cycle
  a_rebuild_bounded: assert property (@(posedge clk) disable iff (rst)
    $rose(busy) |-> ##[1:5] !busy)
    else $error("stride rebuild did not finish");

  a_last_stride_one: assert property (@(posedge clk) disable iff (rst)
    !busy |-> (stride[last_dim] == SW'(1)))
    else $error("innermost stride is not one");

endmodule

// ===== design/nts_back.sv =====
// ----------------------------------------------------------------------------
// nts_back - element store access and result register
// Clears the store after reset, then pops queued requests, reads or writes
// the store and presents one result per request.
// ----------------------------------------------------------------------------
module nts_back #(
  parameter int STORE_DEPTH = 1024,
  parameter int DATA_WIDTH  = 32
) (
  input  logic                                      clk,
  input  logic                                      rst,
  input  nts_pkg::q_status_t                        q_st,
  output logic                                      pop,
  input  logic [$clog2(STORE_DEPTH)+DATA_WIDTH+1:0] pop_data,
  output logic                                      rsp_valid,
  input  logic                                      rsp_stall,
  output logic [nts_pkg::VALUE_W-1:0]               read_value,
  output logic                                      index_error,
  output nts_pkg::back_status_t                     back_st
);
  import nts_pkg::*;

  localparam int ADDR_W = $clog2(STORE_DEPTH);

  logic [DATA_WIDTH-1:0] mem [STORE_DEPTH];

  logic                  clearing;
  logic [ADDR_W-1:0]     clr_addr;

  logic                  e_set;
  logic                  e_err;
  logic [ADDR_W-1:0]     e_addr;
  logic [DATA_WIDTH-1:0] e_data;
  logic                  we;

  logic                  b1_valid;
  logic                  b1_set;
  logic                  b1_err;
  logic [DATA_WIDTH-1:0] rd_data;
  logic                  b1_move;

  assign {e_set, e_err, e_addr, e_data} = pop_data;

  assign b1_move = b1_valid && (!rsp_valid || !rsp_stall);
  assign pop     = !q_st.empty && !clearing && (!b1_valid || b1_move);
  assign we      = pop && e_set && !e_err;

  assign back_st.clearing = clearing;

  // zero sweep after reset, one entry a cycle
  always_ff @(posedge clk) begin
    if (rst) begin
      clearing <= 1'b1;
      clr_addr <= '0;
    end else if (clearing) begin
      clr_addr <= clr_addr + ADDR_W'(1);
      if (clr_addr == ADDR_W'(STORE_DEPTH - 1)) begin
        clearing <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (clearing) begin
      mem[clr_addr] <= '0;
    end else if (we) begin
      mem[e_addr] <= e_data;
    end
    if (pop) begin
      rd_data <= mem[e_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      b1_valid <= 1'b0;
    end else if (pop) begin
      b1_valid <= 1'b1;
    end else if (b1_move) begin
      b1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      b1_set <= e_set;
      b1_err <= e_err;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (!rsp_valid || !rsp_stall) begin
      rsp_valid <= b1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (b1_move) begin
      read_value  <= (b1_set || b1_err) ? '0 : VALUE_W'(rd_data);
      index_error <= b1_err;
    end
  end

  a_idle_while_clearing: assert property (@(posedge clk) disable iff (rst)
    clearing |-> (!b1_valid && !rsp_valid))
    else $error("request in flight during clear sweep");

  a_error_reads_zero: assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && index_error) |-> (read_value == '0))
    else $error("errored request returned data");

endmodule

// ===== design/nd_tensor_element_store_core.sv =====
// ----------------------------------------------------------------------------
// nd_tensor_element_store_core - row-major N-d tensor element store
// Top level: front end, request queue and store back end.
// ----------------------------------------------------------------------------
// A word store addressed by up to four indices in row-major order. Write the
// dimension count and sizes through the cfg port; strides are rebuilt after
// each write to a known register, which holds cfg_ready and the request side
// off meanwhile (a setup step, one multiply per outer stride, a closing step).
// After reset the store is swept to zero, one entry a cycle, so no request
// is taken until the sweep is done. From then on the block sustains one
// request per cycle while no rebuild runs and rsp_stall is low; a request's
// result passes the index products, queue, store read and result register.
// Any active index at or above its dimension size, or a flat address at or
// above STORE_DEPTH, sets index_error; a get returns zero, a set writes nothing.
module nd_tensor_element_store_core #(
  parameter int STORE_DEPTH = 1024,
  parameter int DATA_WIDTH  = 32
) (
  input  logic                            clk,
  input  logic                            rst,
  // request channel
  input  logic                            req_valid,
  output logic                            req_stall,
  input  logic                            req_type,
  input  logic [nts_pkg::IDX_W-1:0]       index_0,
  input  logic [nts_pkg::IDX_W-1:0]       index_1,
  input  logic [nts_pkg::IDX_W-1:0]       index_2,
  input  logic [nts_pkg::IDX_W-1:0]       index_3,
  input  logic [nts_pkg::VALUE_W-1:0]     write_value,
  // result channel
  output logic                            rsp_valid,
  input  logic                            rsp_stall,
  output logic [nts_pkg::VALUE_W-1:0]     read_value,
  output logic                            index_error,
  // configuration writes
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [nts_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [nts_pkg::CFG_DATA_W-1:0]  cfg_data
);
  import nts_pkg::*;

  // queue entry: set flag, error flag, flat address, write word
  localparam int ENTRY_W = $clog2(STORE_DEPTH) + DATA_WIDTH + 2;

  q_status_t          q_st;
  back_status_t       back_st;
  logic               push;
  logic               pop;
  logic [ENTRY_W-1:0] push_data;
  logic [ENTRY_W-1:0] pop_data;

  // front: shape registers, strides, index checks, flat address
  nts_front #(
    .STORE_DEPTH (STORE_DEPTH),
    .DATA_WIDTH  (DATA_WIDTH)
  ) u_front (
    .clk         (clk),
    .rst         (rst),
    .req_valid   (req_valid),
    .req_stall   (req_stall),
    .req_type    (req_type),
    .index_0     (index_0),
    .index_1     (index_1),
    .index_2     (index_2),
    .index_3     (index_3),
    .write_value (write_value),
    .cfg_valid   (cfg_valid),
    .cfg_ready   (cfg_ready),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .back_st     (back_st),
    .q_st        (q_st),
    .push        (push),
    .push_data   (push_data)
  );

  // decouples classification from store access
  nts_queue #(
    .WIDTH (ENTRY_W)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (push_data),
    .pop       (pop),
    .pop_data  (pop_data),
    .q_st      (q_st)
  );

  // back: store sweep, read/write, result register
  nts_back #(
    .STORE_DEPTH (STORE_DEPTH),
    .DATA_WIDTH  (DATA_WIDTH)
  ) u_back (
    .clk         (clk),
    .rst         (rst),
    .q_st        (q_st),
    .pop         (pop),
    .pop_data    (pop_data),
    .rsp_valid   (rsp_valid),
    .rsp_stall   (rsp_stall),
    .read_value  (read_value),
    .index_error (index_error),
    .back_st     (back_st)
  );

endmodule

// ===== dv/tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb - testbench for nd_tensor_element_store_core
// Directed and random get/set requests over many tensor shapes. A scoreboard
// tracks dimensions, strides and store contents, and checks every result.
// ----------------------------------------------------------------------------
module tb;
  import nts_pkg::*;

  localparam int STORE_DEPTH = 1024;
  // strides saturate at the largest 31-bit value
  localparam longint unsigned STRIDE_SAT = 64'h7FFF_FFFF;
  // register codes past the last size register; the block drops these
  localparam int CFG_SPARE_FIRST = int'(CFG_DIM_SIZE_3) + 1;
  localparam int CFG_SPARE_COUNT = 3;
  // cycles with no request accepted on any channel before giving up;
  // this must outlast the clearing sweep that follows reset
  localparam int STALL_LIMIT = 8192;
  localparam int RAND_PHASES = 24;
  localparam int PHASE_REQS  = 75;

  typedef logic [IDX_FIELDS-1:0][IDX_W-1:0] index_set_t;

  typedef struct packed {
    logic [VALUE_W-1:0] read_value;
    logic               index_error;
  } elem_result_t;

  // --------------------------------------------------------------------------
  // Scoreboard: shadow copy of the shape registers, stride table and store.
  // Each accepted request is resolved at once; its result is queued.
  // --------------------------------------------------------------------------
  class elem_store_scoreboard;
    logic [NDIM_W-1:0]  dim_count;
    logic [DIM_W-1:0]   dim_size [IDX_FIELDS];
    longint unsigned    stride   [IDX_FIELDS];
    logic [VALUE_W-1:0] words    [STORE_DEPTH];
    elem_result_t       result_q [$];
    int                 errors;

    function new();
      dim_count = NDIM_W'(1);
      dim_size[0] = 11'd1024;
      for (int i = 1; i < IDX_FIELDS; i++) dim_size[i] = 11'd1;
      for (int i = 0; i < STORE_DEPTH; i++) words[i] = '0;
      errors = 0;
      rebuild_strides();
    endfunction

    // zero counts as one dimension, large counts clip to the supported max
    function int active_dims();
      int n;
      n = int'(dim_count);
      if (n == 0) n = 1;
      if (n > MAX_DIMS) n = MAX_DIMS;
      if (n > IDX_FIELDS) n = IDX_FIELDS;
      return n;
    endfunction

    function void rebuild_strides();
      int n;
      longint unsigned s;
      n = active_dims();
      for (int i = 0; i < IDX_FIELDS; i++) stride[i] = 0;
      stride[n-1] = 1;
      for (int i = n - 1; i > 0; i--) begin
        s = stride[i] * longint'(dim_size[i]);
        if (s > STRIDE_SAT) s = STRIDE_SAT;
        stride[i-1] = s;
      end
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
      if (idx == CFG_NUM_DIMS) begin
        dim_count = data[NDIM_W-1:0];
      end else if (idx <= CFG_DIM_SIZE_3) begin
        dim_size[idx - CFG_DIM_SIZE_0] = data;
      end else begin
        return;
      end
      rebuild_strides();
    endfunction

    function void note_request(logic kind, index_set_t ix, logic [VALUE_W-1:0] wv);
      int n;
      bit err;
      longint unsigned flat;
      elem_result_t r;
      n = active_dims();
      err = 1'b0;
      flat = 0;
      for (int k = 0; k < n; k++) begin
        if ({1'b0, ix[k]} >= dim_size[k]) err = 1'b1;
        flat += longint'(ix[k]) * stride[k];
      end
      if (flat >= STORE_DEPTH) err = 1'b1;
      r.read_value  = '0;
      r.index_error = err;
      if (!err) begin
        if (kind == REQ_SET) words[flat] = wv;
        else r.read_value = words[flat];
      end
      result_q.push_back(r);
    endfunction

    function void check_result(logic [VALUE_W-1:0] rv, logic err);
      elem_result_t e;
      if (result_q.size() == 0) begin
        $error("result with no request outstanding: read_value %h index_error %b", rv, err);
        errors++;
        return;
      end
      e = result_q.pop_front();
      if (rv !== e.read_value) begin
        $error("read_value expected %h actual %h", e.read_value, rv);
        errors++;
      end
      if (err !== e.index_error) begin
        $error("index_error expected %b actual %b", e.index_error, err);
        errors++;
      end
    endfunction

    function int outstanding();
      return result_q.size();
    endfunction
  endclass

  // --------------------------------------------------------------------------
  // DUT signals; every input starts at a known value
  // --------------------------------------------------------------------------
  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  req_valid = 1'b0;
  logic                  req_stall;
  logic                  req_type = REQ_GET;
  logic [IDX_W-1:0]      index_0 = '0;
  logic [IDX_W-1:0]      index_1 = '0;
  logic [IDX_W-1:0]      index_2 = '0;
  logic [IDX_W-1:0]      index_3 = '0;
  logic [VALUE_W-1:0]    write_value = '0;
  logic                  rsp_valid;
  logic                  rsp_stall = 1'b0;
  logic [VALUE_W-1:0]    read_value;
  logic                  index_error;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  elem_store_scoreboard sb;
  bit                   calm = 1'b0;   // no idling on either side while set
  int                   idle_cycles = 0;
  // shape as seen by the stimulus, used to aim indices inside the tensor
  int                   shape_dims = 1;
  int                   shape_size [IDX_FIELDS] = '{1024, 1, 1, 1};
  index_set_t           recent_sets [$];

  nd_tensor_element_store_core #(
    .STORE_DEPTH (STORE_DEPTH),
    .DATA_WIDTH  (VALUE_W)
  ) u_top (
    .clk         (clk),
    .rst         (rst),
    .req_valid   (req_valid),
    .req_stall   (req_stall),
    .req_type    (req_type),
    .index_0     (index_0),
    .index_1     (index_1),
    .index_2     (index_2),
    .index_3     (index_3),
    .write_value (write_value),
    .rsp_valid   (rsp_valid),
    .rsp_stall   (rsp_stall),
    .read_value  (read_value),
    .index_error (index_error),
    .cfg_valid   (cfg_valid),
    .cfg_ready   (cfg_ready),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // result side: random back-pressure, off during the calm stretch
  always @(posedge clk) begin
    rsp_stall <= !calm && ($urandom_range(0, 99) < 8);
  end

  // compare every accepted result against the oldest expectation
  always @(posedge clk) begin
    if (!rst && rsp_valid && !rsp_stall) sb.check_result(read_value, index_error);
  end

  // watchdog: counts cycles in which no channel moves a request
  always @(posedge clk) begin
    if (rst || (req_valid && !req_stall) || (rsp_valid && !rsp_stall) ||
        (cfg_valid && cfg_ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= STALL_LIMIT) begin
        $display("FAIL nd_tensor_element_store_core");
        $finish;
      end
    end
  end

  // gap chance of 8 percent per draw, none while calm
  function automatic bit take_gap();
    return !calm && ($urandom_range(0, 99) < 8);
  endfunction

  function automatic index_set_t mk_idx(int i0, int i1, int i2, int i3);
    index_set_t r;
    r[0] = IDX_W'(i0);
    r[1] = IDX_W'(i1);
    r[2] = IDX_W'(i2);
    r[3] = IDX_W'(i3);
    return r;
  endfunction

  // one request: optional gap, then hold valid and payload until taken.
  // valid is left high; a gap in the next call or a shape change lowers it.
  task automatic send_request(logic kind, index_set_t ix, logic [VALUE_W-1:0] wv);
    while (take_gap()) begin
      req_valid <= 1'b0;
      @(posedge clk);
    end
    req_valid   <= 1'b1;
    req_type    <= kind;
    index_0     <= ix[0];
    index_1     <= ix[1];
    index_2     <= ix[2];
    index_3     <= ix[3];
    write_value <= wv;
    do @(posedge clk); while (req_stall);
    sb.note_request(kind, ix, wv);
  endtask

  task automatic cfg_write(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    while (take_gap()) begin
      cfg_valid <= 1'b0;
      @(posedge clk);
    end
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    sb.write_reg(idx, data);
  endtask

  task automatic wait_drain();
    while (sb.outstanding() != 0) @(posedge clk);
  endtask

  // Reshape: only once the block is idle. All five registers are written in
  // shuffled order, then a number of writes to the unused register codes.
  task automatic set_shape(logic [NDIM_W-1:0] n, logic [DIM_W-1:0] d0, logic [DIM_W-1:0] d1,
                           logic [DIM_W-1:0] d2, logic [DIM_W-1:0] d3, int spare_writes);
    cfg_reg_t        regs [5];
    logic [DIM_W-1:0] vals [5];
    cfg_reg_t        rt;
    logic [DIM_W-1:0] vt;
    int              j;
    int              start;
    req_valid <= 1'b0;
    wait_drain();
    regs[0] = CFG_NUM_DIMS;   vals[0] = DIM_W'(n);
    regs[1] = CFG_DIM_SIZE_0; vals[1] = d0;
    regs[2] = CFG_DIM_SIZE_1; vals[2] = d1;
    regs[3] = CFG_DIM_SIZE_2; vals[3] = d2;
    regs[4] = CFG_DIM_SIZE_3; vals[4] = d3;
    for (int i = 4; i > 0; i--) begin
      j = $urandom_range(0, i);
      rt = regs[i]; regs[i] = regs[j]; regs[j] = rt;
      vt = vals[i]; vals[i] = vals[j]; vals[j] = vt;
    end
    for (int i = 0; i < 5; i++) cfg_write(regs[i], vals[i]);
    start = $urandom_range(0, CFG_SPARE_COUNT - 1);
    for (int i = 0; i < spare_writes; i++)
      cfg_write(CFG_IDX_W'(CFG_SPARE_FIRST + (start + i) % CFG_SPARE_COUNT),
                CFG_DATA_W'($urandom_range(0, 2047)));
    cfg_valid <= 1'b0;
    shape_dims = (n == 0) ? 1 : (int'(n) > MAX_DIMS) ? MAX_DIMS : int'(n);
    shape_size[0] = int'(d0);
    shape_size[1] = int'(d1);
    shape_size[2] = int'(d2);
    shape_size[3] = int'(d3);
  endtask

  // Mostly well-formed shapes whose element count fits the store; one in
  // five is raw register noise (zero sizes, oversize dims, odd counts).
  task automatic random_shape();
    logic [DIM_W-1:0]  d [IDX_FIELDS];
    logic [NDIM_W-1:0] n;
    int                budget;
    int                b;
    if ($urandom_range(0, 4) == 0) begin
      n = NDIM_W'($urandom_range(0, 7));
      for (int k = 0; k < IDX_FIELDS; k++) d[k] = DIM_W'($urandom_range(0, 2047));
    end else begin
      n = NDIM_W'($urandom_range(1, MAX_DIMS));
      budget = 10;
      for (int k = 0; k < IDX_FIELDS; k++) begin
        if (k < int'(n)) begin
          b = $urandom_range(0, budget);
          budget -= b;
          d[k] = DIM_W'($urandom_range(1, 1 << b));
        end else begin
          d[k] = DIM_W'($urandom_range(0, 2047));
        end
      end
    end
    set_shape(n, d[0], d[1], d[2], d[3], ($urandom_range(0, 3) == 0) ? 1 : 0);
  endtask

  // Random get/set: indices mostly inside the tensor, some anywhere in the
  // 10-bit range; some gets revisit recently set elements so reads hit data.
  task automatic issue_random_request();
    index_set_t ix;
    logic       kind;
    int         lim;
    kind = ($urandom_range(0, 99) < 45) ? REQ_SET : REQ_GET;
    if (kind == REQ_GET && recent_sets.size() > 0 && $urandom_range(0, 99) < 30) begin
      ix = recent_sets[$urandom_range(0, recent_sets.size() - 1)];
    end else begin
      for (int k = 0; k < IDX_FIELDS; k++) begin
        lim = (shape_size[k] > 1024) ? 1024 : shape_size[k];
        if (k < shape_dims && lim > 0 && $urandom_range(0, 99) < 88)
          ix[k] = IDX_W'($urandom_range(0, lim - 1));
        else
          ix[k] = IDX_W'($urandom_range(0, 1023));
      end
    end
    send_request(kind, ix, $urandom());
    if (kind == REQ_SET) begin
      recent_sets.push_back(ix);
      if (recent_sets.size() > 8) void'(recent_sets.pop_front());
    end
  endtask

  // --------------------------------------------------------------------------
  // Main sequence
  // --------------------------------------------------------------------------
  initial begin
    sb = new();
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    // reset shape, 1-d of 1024; first request waits out the clearing sweep
    send_request(REQ_SET, mk_idx(0, 1023, 1023, 1023), 32'hFFFF_FFFF);
    send_request(REQ_SET, mk_idx(1023, 0, 0, 0), 32'h5A5A_A5A5);
    send_request(REQ_GET, mk_idx(0, 0, 0, 0), 32'h0);
    send_request(REQ_GET, mk_idx(1023, 511, 7, 1023), 32'hFFFF_FFFF);
    // never written: must read back as cleared
    send_request(REQ_GET, mk_idx(512, 0, 0, 0), 32'h0);
    send_request(REQ_SET, mk_idx(1, 0, 0, 0), 32'h0);
    send_request(REQ_GET, mk_idx(1, 0, 0, 0), 32'h0);

    // 32x32: corner maps onto the last flat word; each index bound checked
    set_shape(2, 32, 32, 1, 1, 0);
    send_request(REQ_GET, mk_idx(31, 31, 0, 0), 32'h0);
    send_request(REQ_GET, mk_idx(32, 0, 0, 0), 32'h0);
    send_request(REQ_GET, mk_idx(0, 32, 0, 0), 32'h0);
    // set in error must leave the store alone
    send_request(REQ_SET, mk_idx(0, 40, 0, 0), 32'h1234_5678);
    send_request(REQ_GET, mk_idx(0, 8, 0, 0), 32'h0);
    send_request(REQ_SET, mk_idx(31, 0, 0, 0), 32'hC0DE_0992);

    // 4-d of 2047 each: outer stride saturates; in-range indices can still
    // land past the end of the store
    set_shape(4, 2047, 2047, 2047, 2047, 0);
    send_request(REQ_GET, mk_idx(0, 0, 0, 1023), 32'h0);
    send_request(REQ_GET, mk_idx(1, 0, 0, 0), 32'h0);
    send_request(REQ_GET, mk_idx(0, 0, 1, 0), 32'h0);
    send_request(REQ_SET, mk_idx(0, 1, 0, 0), 32'hDEAD_BEEF);

    // a zero-size dimension rejects everything
    set_shape(3, 4, 0, 4, 1, 0);
    send_request(REQ_GET, mk_idx(0, 0, 0, 0), 32'h0);

    // count zero acts as 1-d; spare register codes are written and ignored
    set_shape(0, 1024, 0, 0, 0, CFG_SPARE_COUNT);
    send_request(REQ_GET, mk_idx(992, 5, 5, 5), 32'h0);

    // count seven clips to four dimensions
    set_shape(7, 4, 4, 8, 8, 0);
    send_request(REQ_SET, mk_idx(3, 3, 7, 7), 32'h0F0F_F0F0);
    send_request(REQ_GET, mk_idx(3, 3, 7, 7), 32'h0);
    send_request(REQ_GET, mk_idx(0, 0, 0, 8), 32'h0);

    // size above 1024 compares as written
    set_shape(1, 2047, 1, 1, 1, 0);
    send_request(REQ_GET, mk_idx(1023, 0, 0, 0), 32'h0);

    // random phases, one shape each; a stretch in the middle runs calm
    for (int ph = 0; ph < RAND_PHASES; ph++) begin
      calm = (ph >= 10 && ph < 13);
      random_shape();
      for (int j = 0; j < PHASE_REQS; j++) issue_random_request();
    end
    calm = 1'b0;

    req_valid <= 1'b0;
    wait_drain();
    repeat (8) @(posedge clk);
    if (sb.outstanding() != 0)
      $error("%0d results never arrived", sb.outstanding());
    if (sb.errors == 0 && sb.outstanding() == 0) begin
      $display("PASS nd_tensor_element_store_core");
    end else begin
      $display("FAIL nd_tensor_element_store_core");
    end
    $finish;
  end

endmodule
